// ===== hdl/npc_pkg.sv =====
// ----------------------------------------------------------------------------
// npc_pkg
// Shared widths, codes and defaults for the nearest palette color search.
// ----------------------------------------------------------------------------
`default_nettype none

package npc_pkg;

    localparam int PALETTE_ENTRIES_DEF = 256;

    localparam int KIND_W  = 1;
    localparam int INDEX_W = 8;   // width of entry_index and closest_index
    localparam int COLOR_W = 16;  // RGB565
    localparam int CHAN_W  = 8;
    localparam int SQ_W    = 2 * CHAN_W;
    localparam int DIST_W  = SQ_W + 2;  // 3 * 255 * 255 fits in 18 bits

    localparam logic [KIND_W-1:0] KIND_WRITE = 1'b0;
    localparam logic [KIND_W-1:0] KIND_QUERY = 1'b1;

endpackage

`default_nettype wire

// ===== hdl/nearest_palette_color.sv =====
// ----------------------------------------------------------------------------
// nearest_palette_color
// RGB565 palette with a nearest-color lookup by squared RGB distance.
// ----------------------------------------------------------------------------
// A write item stores one RGB565 entry and gives no result. A query item
// scans the whole palette: the palette memory has one read port, so the scan
// reads one entry per cycle and feeds it to a single distance unit (channel
// expansion, three 8x8 squarers, sum and running minimum). The read data,
// the squares and the running minimum are registered in turn, and the result
// then loads the output register. The block is ready again in the cycle the
// result appears, so a new query is never taken before the previous one's
// result is shown. The block takes no item while a query is scanning or
// while a finished query waits for a full output register. Every entry
// reads as zero after reset until it is written.
`default_nettype none

module nearest_palette_color #(
    parameter int PALETTE_ENTRIES = npc_pkg::PALETTE_ENTRIES_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [npc_pkg::KIND_W-1:0]    kind,
    input  wire logic [npc_pkg::INDEX_W-1:0]   entry_index,
    input  wire logic [npc_pkg::COLOR_W-1:0]   entry_color,
    input  wire logic [npc_pkg::CHAN_W-1:0]    red,
    input  wire logic [npc_pkg::CHAN_W-1:0]    green,
    input  wire logic [npc_pkg::CHAN_W-1:0]    blue,

    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [npc_pkg::INDEX_W-1:0]        closest_index
);
    import npc_pkg::*;

    localparam int IDX_W = $clog2(PALETTE_ENTRIES);
    localparam logic [IDX_W-1:0]   LAST_IDX   = IDX_W'(PALETTE_ENTRIES - 1);
    localparam logic [INDEX_W:0]   SLOT_LIMIT = (INDEX_W + 1)'(PALETTE_ENTRIES);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t                  state_reg;
    logic [IDX_W-1:0]        rd_idx_reg;
    logic                    issue_reg;
    logic                    p1_v_reg;
    logic                    p2_v_reg;
    logic [IDX_W-1:0]        best_idx_reg;
    logic [DIST_W-1:0]       best_sum_reg;
    logic                    out_valid_reg;
    logic [INDEX_W-1:0]      closest_reg;

    logic [COLOR_W-1:0]      mem [PALETTE_ENTRIES];
    logic [PALETTE_ENTRIES-1:0] vld_reg;

    logic [CHAN_W-1:0]       q_r_reg, q_g_reg, q_b_reg;
    logic [COLOR_W-1:0]      rd_data_reg;
    logic                    rd_vld_reg;
    logic [IDX_W-1:0]        p1_idx_reg;
    logic [IDX_W-1:0]        p2_idx_reg;
    logic [SQ_W-1:0]         sq_r_reg, sq_g_reg, sq_b_reg;

    logic                    accept;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_idx;
    logic [COLOR_W-1:0]      entry;
    logic [CHAN_W-1:0]       pr, pg, pb;
    logic [CHAN_W-1:0]       dr, dg, db;
    logic [DIST_W-1:0]       sum;
    logic                    take_best;

    assign in_ready      = (state_reg == ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign closest_index = closest_reg;

    assign accept = in_valid && in_ready;
    assign wr_en  = accept && (kind == KIND_WRITE)
                    && ({1'b0, entry_index} < SLOT_LIMIT);
    assign wr_idx = entry_index[IDX_W-1:0];

    // Distance unit, stage 1: expand the entry and square channel differences
    always_comb
    begin
        entry = rd_vld_reg ? rd_data_reg : '0;
        pr    = {entry[15:11], 3'b000};
        pg    = {entry[10:5], 2'b00};
        pb    = {entry[4:0], 3'b000};
        dr    = (q_r_reg >= pr) ? (q_r_reg - pr) : (pr - q_r_reg);
        dg    = (q_g_reg >= pg) ? (q_g_reg - pg) : (pg - q_g_reg);
        db    = (q_b_reg >= pb) ? (q_b_reg - pb) : (pb - q_b_reg);
    end

    // Stage 2: sum and running minimum; strict compare keeps the lowest index
    assign sum = DIST_W'(sq_r_reg) + DIST_W'(sq_g_reg) + DIST_W'(sq_b_reg);
    assign take_best = (p2_idx_reg == '0) || (sum < best_sum_reg);

    // Palette memory and datapath registers
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= entry_color;
        end
        rd_data_reg <= mem[rd_idx_reg];
        rd_vld_reg  <= vld_reg[rd_idx_reg];
        p1_idx_reg  <= rd_idx_reg;
        p2_idx_reg  <= p1_idx_reg;
        sq_r_reg    <= SQ_W'(dr) * SQ_W'(dr);
        sq_g_reg    <= SQ_W'(dg) * SQ_W'(dg);
        sq_b_reg    <= SQ_W'(db) * SQ_W'(db);
        if (accept && (kind == KIND_QUERY))
        begin
            q_r_reg <= red;
            q_g_reg <= green;
            q_b_reg <= blue;
        end
        if (p2_v_reg && take_best)
        begin
            best_sum_reg <= sum;
            best_idx_reg <= p2_idx_reg;
        end
    end

    // Written-entry flags; an unwritten entry reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (wr_en)
        begin
            vld_reg[wr_idx] <= 1'b1;
        end
    end

    // Scan sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_idx_reg    <= '0;
            issue_reg     <= 1'b0;
            p1_v_reg      <= 1'b0;
            p2_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            closest_reg   <= '0;
        end
        else
        begin
            // ST_DONE handles its own output handoff
            if (out_valid_reg && out_ready && (state_reg != ST_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept && (kind == KIND_QUERY))
                    begin
                        state_reg  <= ST_SCAN;
                        rd_idx_reg <= '0;
                        issue_reg  <= 1'b1;
                        p1_v_reg   <= 1'b0;
                        p2_v_reg   <= 1'b0;
                    end
                end
                ST_SCAN:
                begin
                    p1_v_reg <= issue_reg;
                    p2_v_reg <= p1_v_reg;
                    if (issue_reg)
                    begin
                        if (rd_idx_reg == LAST_IDX)
                        begin
                            issue_reg <= 1'b0;
                        end
                        else
                        begin
                            rd_idx_reg <= rd_idx_reg + IDX_W'(1);
                        end
                    end
                    if (p2_v_reg && (p2_idx_reg == LAST_IDX))
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    p1_v_reg <= 1'b0;
                    p2_v_reg <= 1'b0;
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        closest_reg   <= INDEX_W'(best_idx_reg);
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hdl/npc_checker.sv =====
// ----------------------------------------------------------------------------
// npc_checker
// Port-level checks for the nearest palette color search, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module npc_checker #(
    parameter int PALETTE_ENTRIES = npc_pkg::PALETTE_ENTRIES_DEF
) (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_ready,
    input wire logic [npc_pkg::KIND_W-1:0]    kind,
    input wire logic [npc_pkg::INDEX_W-1:0]   entry_index,
    input wire logic [npc_pkg::COLOR_W-1:0]   entry_color,
    input wire logic [npc_pkg::CHAN_W-1:0]    red,
    input wire logic [npc_pkg::CHAN_W-1:0]    green,
    input wire logic [npc_pkg::CHAN_W-1:0]    blue,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic [npc_pkg::INDEX_W-1:0]   closest_index
);
    import npc_pkg::*;

    localparam logic [INDEX_W:0] SLOT_LIMIT = (INDEX_W + 1)'(PALETTE_ENTRIES);

    logic unused_fields;
    assign unused_fields = ^{entry_index, entry_color, red, green, blue};

    // A result that waits holds its index
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(closest_index))
        else $error("result changed while stalled");

    // Every result names a real palette slot
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({1'b0, closest_index} < SLOT_LIMIT))
        else $error("closest_index beyond palette");

    // A write item never produces a result
    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (kind == KIND_WRITE) && !out_valid |=> !out_valid)
        else $error("result after write item");

    // A query occupies the block: no item taken in the following cycle
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (kind == KIND_QUERY) |=> !in_ready)
        else $error("item accepted during scan");

endmodule

bind nearest_palette_color npc_checker #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
) u_npc_checker (.*);

`default_nettype wire

// ===== tb/nearest_palette_color_tb.sv =====
// ----------------------------------------------------------------------------
// nearest_palette_color_tb
// Self-checking bench for the RGB565 nearest palette color search. A mirror
// of the palette is kept here and each query's expected slot is worked out
// by a full scan of that mirror at acceptance. Directed items cover the
// cleared palette, channel extremes and tie-breaking. A long output stall
// follows, then random traffic under changing input/output throttling.
// ----------------------------------------------------------------------------
module nearest_palette_color_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import npc_pkg::*;

    localparam int ENTRIES     = PALETTE_ENTRIES_DEF;
    localparam int SCAN_CYCLES = ENTRIES + 4;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int REPORT_MAX  = 10;
    localparam int RANDOM_ITEMS_PER_PHASE = 508;

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                in_valid    = 1'b0;
    logic                in_ready;
    logic [KIND_W-1:0]   kind        = KIND_WRITE;
    logic [INDEX_W-1:0]  entry_index = '0;
    logic [COLOR_W-1:0]  entry_color = '0;
    logic [CHAN_W-1:0]   red         = '0;
    logic [CHAN_W-1:0]   green       = '0;
    logic [CHAN_W-1:0]   blue        = '0;
    logic                out_valid;
    logic                out_ready   = 1'b0;
    logic [INDEX_W-1:0]  closest_index;

    // palette as the block should hold it, and slots still owed by the block
    logic [COLOR_W-1:0]  palette_mirror [ENTRIES];
    logic [INDEX_W-1:0]  closest_expected [$];
    logic [INDEX_W-1:0]  closest_want;

    int mismatch_count = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;

    // output stall requests: bump hold_req_seq to start a stall of hold_len_req
    int hold_len_req   = 0;
    int hold_req_seq   = 0;
    int hold_seq_seen  = 0;
    int hold_left      = 0;

    nearest_palette_color DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .entry_index   (entry_index),
        .entry_color   (entry_color),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .closest_index (closest_index)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [INDEX_W-1:0] nearest_entry(
        input logic [CHAN_W-1:0] r,
        input logic [CHAN_W-1:0] g,
        input logic [CHAN_W-1:0] b
    );
        logic [COLOR_W-1:0] e;
        logic [INDEX_W-1:0] best;
        int                 best_sum;
        int                 sum;
        int                 dr;
        int                 dg;
        int                 db;
        best     = '0;
        best_sum = 0;
        for (int k = 0; k < ENTRIES; k++)
        begin
            e   = palette_mirror[k];
            dr  = int'(r) - int'({e[15:11], 3'b000});
            dg  = int'(g) - int'({e[10:5], 2'b00});
            db  = int'(b) - int'({e[4:0], 3'b000});
            sum = dr * dr + dg * dg + db * db;
            // strict compare keeps the lowest slot on a tie
            if (k == 0 || sum < best_sum)
            begin
                best_sum = sum;
                best     = INDEX_W'(k);
            end
        end
        return best;
    endfunction

    function automatic logic [CHAN_W-1:0] jitter_channel(input logic [CHAN_W-1:0] c);
        int v;
        v = int'(c) + int'($urandom_range(0, 12)) - 6;
        if (v < 0)
            v = 0;
        else if (v > 255)
            v = 255;
        return CHAN_W'(v);
    endfunction

    // Offers one item and returns at the edge that accepts it; valid stays
    // high on return so a back-to-back item never drops it.
    task automatic send_item(
        input logic [KIND_W-1:0]  k,
        input logic [INDEX_W-1:0] idx,
        input logic [COLOR_W-1:0] col,
        input logic [CHAN_W-1:0]  r,
        input logic [CHAN_W-1:0]  g,
        input logic [CHAN_W-1:0]  b
    );
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        kind        <= k;
        entry_index <= idx;
        entry_color <= col;
        red         <= r;
        green       <= g;
        blue        <= b;
        do
            @(posedge clk);
        while (!in_ready);
        if (k == KIND_WRITE)
        begin
            if (int'(idx) < ENTRIES)
                palette_mirror[idx] = col;
        end
        else
        begin
            closest_expected.push_back(nearest_entry(r, g, b));
        end
    endtask

    // unused fields carry random junk
    task automatic send_write(input logic [INDEX_W-1:0] idx, input logic [COLOR_W-1:0] col);
        send_item(KIND_WRITE, idx, col, CHAN_W'($urandom), CHAN_W'($urandom),
                  CHAN_W'($urandom));
    endtask

    task automatic send_query(
        input logic [CHAN_W-1:0] r,
        input logic [CHAN_W-1:0] g,
        input logic [CHAN_W-1:0] b
    );
        send_item(KIND_QUERY, INDEX_W'($urandom), COLOR_W'($urandom), r, g, b);
    endtask

    task automatic drain_results;
        in_valid <= 1'b0;
        @(posedge clk);
        while (closest_expected.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_cleared_palette;
        send_query(8'h00, 8'h00, 8'h00);
        send_query(8'hFF, 8'hFF, 8'hFF);
        send_query(CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom));
    endtask

    task automatic test_channel_extremes;
        send_write(8'd0,   16'h0000);
        send_write(8'd255, 16'hFFFF);
        send_write(8'd128, 16'hF800);
        send_write(8'd1,   16'h07E0);
        send_write(8'd2,   16'h001F);
        send_query(8'hFF, 8'hFF, 8'hFF);
        send_query(8'h00, 8'h00, 8'h00);
        send_query(8'hFF, 8'h00, 8'h00);
        send_query(8'h00, 8'hFF, 8'h00);
        send_query(8'h00, 8'h00, 8'hFF);
    endtask

    task automatic test_tie_break;
        // identical colors in two slots, then two colors equally far away
        send_write(8'd10, 16'h8410);
        send_write(8'd20, 16'h8410);
        send_write(8'd30, 16'h1000);
        send_write(8'd40, 16'h0800);
        send_query(8'h80, 8'h80, 8'h80);
        send_query(8'd12, 8'h00, 8'h00);
        send_write(8'd10, 16'h0000);
        send_query(8'h80, 8'h80, 8'h80);
    endtask

    task automatic test_output_stall;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_len_req  = 1500;
        hold_req_seq++;
        repeat (5)
            send_query(CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom));
        drain_results;
    endtask

    task automatic test_random_traffic(input int n, input int send_pct, input int recv_pct);
        int                 pick;
        logic [INDEX_W-1:0] slot;
        logic [COLOR_W-1:0] col;
        logic [CHAN_W-1:0]  r;
        logic [CHAN_W-1:0]  g;
        logic [CHAN_W-1:0]  b;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (n)
        begin
            if ($urandom_range(0, 99) < 45)
            begin
                slot = INDEX_W'($urandom);
                pick = $urandom_range(0, 9);
                if (pick < 6)
                    col = COLOR_W'($urandom);
                else if (pick < 8)
                    col = palette_mirror[$urandom_range(0, ENTRIES - 1)];  // makes ties
                else if (pick == 8)
                    col = '1;
                else
                    col = '0;
                send_write(slot, col);
            end
            else
            begin
                pick = $urandom_range(0, 9);
                col  = palette_mirror[$urandom_range(0, ENTRIES - 1)];
                r    = {col[15:11], 3'b000};
                g    = {col[10:5], 2'b00};
                b    = {col[4:0], 3'b000};
                if (pick < 4)
                begin
                    r = CHAN_W'($urandom);
                    g = CHAN_W'($urandom);
                    b = CHAN_W'($urandom);
                end
                else if (pick < 8)
                begin
                    r = jitter_channel(r);
                    g = jitter_channel(g);
                    b = jitter_channel(b);
                end
                send_query(r, g, b);
            end
        end
    endtask

    // result checker, output throttling and run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (closest_expected.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("cycle %0d: unexpected result closest_index=%0d",
                                 cycle_count, closest_index);
                end
                else
                begin
                    closest_want = closest_expected.pop_front();
                    if (closest_index !== closest_want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX)
                            $display("cycle %0d: closest_index expected %0d got %0d",
                                     cycle_count, closest_want, closest_index);
                    end
                end
            end
            if (hold_req_seq != hold_seq_seen)
            begin
                hold_seq_seen = hold_req_seq;
                hold_left     = hold_len_req;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    initial
    begin
        for (int k = 0; k < ENTRIES; k++)
            palette_mirror[k] = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_cleared_palette;
        test_channel_extremes;
        test_tie_break;
        drain_results;
        test_output_stall;
        test_random_traffic(RANDOM_ITEMS_PER_PHASE, 36, 64);
        test_random_traffic(RANDOM_ITEMS_PER_PHASE, 64, 36);
        test_random_traffic(RANDOM_ITEMS_PER_PHASE, 0, 0);

        drain_results;
        repeat (SCAN_CYCLES + 4) @(posedge clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
